// File: src/pfde_pkg.sv
package pfde_pkg;

  // default screen size
  localparam int unsigned SCREEN_WIDTH_DEFAULT  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEFAULT = 128;

  // command codes
  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_SET    = 3'd1,
    OP_FILL   = 3'd2,
    OP_RECT   = 3'd3,
    OP_CIRCLE = 3'd4
  } op_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BOUNDS,
    ST_START,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_RESULT
  } ctl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic clear;
    logic bounds;
    logic start;
    logic step;
    logic read;
    logic load_result;
  } pfde_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic span_empty;
    logic span_last;
    logic pipe_busy;
  } pfde_stat_t;

  // fixed sixteen-color palette
  function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
    logic [23:0] rgb;
    unique case (idx)
      4'd0:  rgb = 24'h000000;
      4'd1:  rgb = 24'h1D2B53;
      4'd2:  rgb = 24'h7E2553;
      4'd3:  rgb = 24'h008751;
      4'd4:  rgb = 24'hAB5236;
      4'd5:  rgb = 24'h5F574F;
      4'd6:  rgb = 24'hC2C3C7;
      4'd7:  rgb = 24'hFFF1E8;
      4'd8:  rgb = 24'hFF004D;
      4'd9:  rgb = 24'hFFA300;
      4'd10: rgb = 24'hFFEC27;
      4'd11: rgb = 24'h00E436;
      4'd12: rgb = 24'h29ADFF;
      4'd13: rgb = 24'h83769C;
      4'd14: rgb = 24'hFF77A8;
      4'd15: rgb = 24'hFFCCAA;
    endcase
    return rgb;
  endfunction

endpackage

// File: src/pfde_datapath.sv
module pfde_datapath
  import pfde_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEFAULT,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfde_cmd_t          cmd_i,
  output pfde_stat_t         stat_o,
  input  logic [2:0]         operation_i,
  input  logic signed [15:0] x_a_i,
  input  logic signed [15:0] y_a_i,
  input  logic signed [15:0] x_b_i,
  input  logic signed [15:0] y_b_i,
  input  logic signed [15:0] radius_i,
  input  logic [7:0]         color_i,
  output logic [23:0]        pixel_rgb_o,
  output logic               applied_o
);

  localparam int unsigned DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned XW    = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int unsigned YW    = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam logic signed [17:0] W_S = 18'(SCREEN_WIDTH);
  localparam logic signed [17:0] H_S = 18'(SCREEN_HEIGHT);
  localparam logic [AW-1:0] W_A = AW'(SCREEN_WIDTH);

  // clamp into [0, size-1]
  function automatic logic signed [17:0] clamp_sz(input logic signed [17:0] v,
                                                 input logic signed [17:0] size);
    logic signed [17:0] res;
    if (v < 18'sd0) begin
      res = 18'sd0;
    end else if (v >= size) begin
      res = size - 18'sd1;
    end else begin
      res = v;
    end
    return res;
  endfunction

  // captured command fields
  logic [2:0]         op_q;
  logic signed [15:0] xa_q, ya_q, xb_q, yb_q, r_q;
  logic [7:0]         color_q;

  // span registers
  logic [XW-1:0] xlo_q, xlast_q, x_q;
  logic [YW-1:0] ylo_q, ylast_q, y_q;
  logic          empty_q;
  logic          circ_q;
  logic [3:0]    wcolor_q;
  logic [29:0]   r2_q;
  logic [AW-1:0] row_q, addr_q;

  // pixel pipeline
  logic          v1_q;
  logic [AW-1:0] addr1_q;
  logic [29:0]   dx2_q, dy2_q;

  logic [3:0]    mem [DEPTH];
  logic [3:0]    rdata_q;
  logic [23:0]   pixel_rgb_q;
  logic          applied_q;

  op_e                op;
  logic               color_ok;
  logic signed [17:0] xa_s, ya_s, xb_s, yb_s, r_s;
  logic signed [17:0] xlo_raw, xhi_raw, ylo_raw, yhi_raw;
  logic signed [17:0] xlo_c, xhi_c, ylo_c, yhi_c, xlast_c, ylast_c;
  logic               op_ok, empty_d;
  logic [14:0]        r_mag;
  logic [29:0]        r2_d;

  assign op       = op_e'(op_q);
  assign color_ok = (color_q[7:4] == 4'd0);
  assign xa_s     = {{2{xa_q[15]}}, xa_q};
  assign ya_s     = {{2{ya_q[15]}}, ya_q};
  assign xb_s     = {{2{xb_q[15]}}, xb_q};
  assign yb_s     = {{2{yb_q[15]}}, yb_q};
  assign r_s      = {{2{r_q[15]}}, r_q};
  assign r_mag    = r_q[14:0];
  assign r2_d     = {15'd0, r_mag} * {15'd0, r_mag};

  // raw span per command, then clip to the screen
  always_comb begin
    xlo_raw = 18'sd0;
    xhi_raw = 18'sd0;
    ylo_raw = 18'sd0;
    yhi_raw = 18'sd0;
    op_ok   = 1'b0;
    if (cmd_i.clear) begin
      xhi_raw = W_S;
      yhi_raw = H_S;
      op_ok   = 1'b1;
    end else begin
      unique case (op)
        OP_READ: begin
          xlo_raw = xa_s;
          xhi_raw = xa_s + 18'sd1;
          ylo_raw = ya_s;
          yhi_raw = ya_s + 18'sd1;
          op_ok   = 1'b1;
        end
        OP_SET: begin
          xlo_raw = xa_s;
          xhi_raw = xa_s + 18'sd1;
          ylo_raw = ya_s;
          yhi_raw = ya_s + 18'sd1;
          op_ok   = color_ok;
        end
        OP_FILL: begin
          xhi_raw = W_S;
          yhi_raw = H_S;
          op_ok   = color_ok;
        end
        OP_RECT: begin
          xlo_raw = clamp_sz(xa_s, W_S);
          xhi_raw = clamp_sz(xb_s, W_S);
          ylo_raw = clamp_sz(ya_s, H_S);
          yhi_raw = clamp_sz(yb_s, H_S);
          op_ok   = color_ok;
        end
        OP_CIRCLE: begin
          xlo_raw = xa_s - r_s;
          xhi_raw = xa_s + r_s;
          ylo_raw = ya_s - r_s;
          yhi_raw = ya_s + r_s;
          op_ok   = color_ok;
        end
        default: begin
          op_ok = 1'b0;
        end
      endcase
    end
    xlo_c   = (xlo_raw < 18'sd0) ? 18'sd0 : xlo_raw;
    ylo_c   = (ylo_raw < 18'sd0) ? 18'sd0 : ylo_raw;
    xhi_c   = (xhi_raw > W_S) ? W_S : xhi_raw;
    yhi_c   = (yhi_raw > H_S) ? H_S : yhi_raw;
    xlast_c = xhi_c - 18'sd1;
    ylast_c = yhi_c - 18'sd1;
    empty_d = !op_ok || (xlo_c >= xhi_c) || (ylo_c >= yhi_c);
  end

  // circle distance terms for the current pixel
  logic signed [17:0] dx_s, dy_s, dx_a, dy_a;
  logic [14:0]        dx_m, dy_m;
  logic [29:0]        dx2_d, dy2_d;
  logic               span_last, hit, we;
  logic [AW-1:0]      row_next;

  assign dx_s  = xa_s - {{(18 - XW){1'b0}}, x_q};
  assign dy_s  = ya_s - {{(18 - YW){1'b0}}, y_q};
  assign dx_a  = dx_s[17] ? -dx_s : dx_s;
  assign dy_a  = dy_s[17] ? -dy_s : dy_s;
  assign dx_m  = dx_a[14:0];
  assign dy_m  = dy_a[14:0];
  assign dx2_d = {15'd0, dx_m} * {15'd0, dx_m};
  assign dy2_d = {15'd0, dy_m} * {15'd0, dy_m};

  assign span_last = (x_q == xlast_q) && (y_q == ylast_q);
  assign row_next  = row_q + W_A;

  // write stage: circle test on registered squares
  assign hit = !circ_q || (({1'b0, dx2_q} + {1'b0, dy2_q}) < {1'b0, r2_q});
  assign we  = v1_q && hit;

  // command capture, span setup and iterator
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q    <= operation_i;
      xa_q    <= x_a_i;
      ya_q    <= y_a_i;
      xb_q    <= x_b_i;
      yb_q    <= y_b_i;
      r_q     <= radius_i;
      color_q <= color_i;
    end
    if (cmd_i.bounds) begin
      xlo_q    <= xlo_c[XW-1:0];
      xlast_q  <= xlast_c[XW-1:0];
      ylo_q    <= ylo_c[YW-1:0];
      ylast_q  <= ylast_c[YW-1:0];
      empty_q  <= empty_d;
      circ_q   <= !cmd_i.clear && (op == OP_CIRCLE);
      wcolor_q <= cmd_i.clear ? 4'd0 : color_q[3:0];
      r2_q     <= r2_d;
    end
    if (cmd_i.start) begin
      x_q    <= xlo_q;
      y_q    <= ylo_q;
      row_q  <= AW'(ylo_q) * W_A + AW'(xlo_q);
      addr_q <= AW'(ylo_q) * W_A + AW'(xlo_q);
    end else if (cmd_i.step) begin
      if (x_q == xlast_q) begin
        x_q    <= xlo_q;
        y_q    <= y_q + YW'(1);
        row_q  <= row_next;
        addr_q <= row_next;
      end else begin
        x_q    <= x_q + XW'(1);
        addr_q <= addr_q + AW'(1);
      end
    end
  end

  // pixel pipeline valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.step;
    end
  end

  // pixel pipeline payload
  always_ff @(posedge clk_i) begin
    addr1_q <= addr_q;
    dx2_q   <= dx2_d;
    dy2_q   <= dy2_d;
  end

  // frame store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[addr1_q] <= wcolor_q;
    end
    if (cmd_i.read && !empty_q) begin
      rdata_q <= mem[addr_q];
    end
  end

  // result
  logic        applied_d;
  logic [23:0] rgb_d;

  always_comb begin
    unique case (op)
      OP_READ:   applied_d = !empty_q;
      OP_SET:    applied_d = !empty_q;
      OP_FILL:   applied_d = color_ok;
      OP_RECT:   applied_d = color_ok;
      OP_CIRCLE: applied_d = color_ok;
      default:   applied_d = 1'b0;
    endcase
    rgb_d = ((op == OP_READ) && !empty_q) ? palette_rgb(rdata_q) : 24'd0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_result) begin
      pixel_rgb_q <= rgb_d;
      applied_q   <= applied_d;
    end
  end

  assign pixel_rgb_o = pixel_rgb_q;
  assign applied_o   = applied_q;

  assign stat_o.is_read    = (op == OP_READ);
  assign stat_o.span_empty = empty_q;
  assign stat_o.span_last  = span_last;
  assign stat_o.pipe_busy  = v1_q;

endmodule

// File: src/pfde_ctrl.sv
module pfde_ctrl
  import pfde_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  pfde_stat_t stat_i,
  output pfde_cmd_t  cmd_o
);

  ctl_state_e state_q, state_d;
  logic       clear_q, clear_d;
  logic       out_valid_q, out_valid_d;

  // state, clear pass flag and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_BOUNDS;
      clear_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clear_q     <= clear_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    clear_d    = clear_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_BOUNDS;
        end
      end
      ST_BOUNDS: begin
        cmd_o.bounds = 1'b1;
        cmd_o.clear  = clear_q;
        state_d      = ST_START;
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        priority if (!clear_q && stat_i.is_read) begin
          state_d = ST_READ;
        end else if (stat_i.span_empty) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.step = 1'b1;
        if (stat_i.span_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          if (clear_q) begin
            clear_d = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end
      ST_READ: begin
        cmd_o.read = 1'b1;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_result = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    if (cmd_o.load_result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/palette_framebuffer_draw_engine_core.sv
// Draw engine for a SCREEN_WIDTH x SCREEN_HEIGHT framebuffer of 4-bit palette
// indices. One command is handled at a time and yields exactly one result
// transaction. Drawing runs through a single pixel iterator that visits one
// pixel per clock and writes the covered pixels into the frame store. After the
// accepting edge in_ready_o stays low through setup and result plus a sweep
// over the command's clipped span: a fill covers W*H pixels, a rectangle
// (x2-x1)*(y2-y1), a circle its clipped bounding square of up to (2r)^2
// pixels and a set pixel one; a read does no sweep. A command whose span is
// empty or that is rejected skips the sweep. After reset the frame store is
// cleared to index 0 by the same iterator while in_ready_o stays low. A
// finished result waits in an output register while the next command is
// accepted; the next result cannot load until that one is taken, so that
// command waits in its result state until then.
module palette_framebuffer_draw_engine_core
  import pfde_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEFAULT,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic signed [15:0] x_a_i,
  input  logic signed [15:0] y_a_i,
  input  logic signed [15:0] x_b_i,
  input  logic signed [15:0] y_b_i,
  input  logic signed [15:0] radius_i,
  input  logic [7:0]         color_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [23:0]        pixel_rgb_o,
  output logic               applied_o
);

  pfde_cmd_t  cmd;
  pfde_stat_t stat;

  // sequencing and handshakes
  pfde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // span setup, pixel pipeline, frame store and result
  pfde_datapath #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .operation_i(operation_i),
    .x_a_i      (x_a_i),
    .y_a_i      (y_a_i),
    .x_b_i      (x_b_i),
    .y_b_i      (y_b_i),
    .radius_i   (radius_i),
    .color_i    (color_i),
    .pixel_rgb_o(pixel_rgb_o),
    .applied_o  (applied_o)
  );

endmodule

// File: src/pfde_checker.sv
module pfde_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [23:0] pixel_rgb_o,
  input logic        applied_o
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before it was taken");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pixel_rgb_o) && $stable(applied_o))
    else $error("stalled result changed");

  // a command that is not carried out returns no color
  a_rgb_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !applied_o |-> pixel_rgb_o == 24'd0)
    else $error("color returned for a command that was not applied");

  // one command at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second command taken while busy");

endmodule

bind palette_framebuffer_draw_engine_core pfde_checker u_pfde_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .pixel_rgb_o(pixel_rgb_o),
  .applied_o  (applied_o)
);
